// ===== rtl/aet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_pkg
// Shared constants and types for the adaptive event trigger.
// ----------------------------------------------------------------------------
package aet_pkg;

    localparam int AET_WINDOW_LEN    = 20;
    localparam int AET_TIMEOUT_TICKS = 500;

    localparam int SAMPLE_W = 32;
    localparam int BASE_W   = 31;
    localparam int GAIN_W   = 20;
    localparam int TICK_W   = 9;
    localparam int FRAC_W   = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic shift;
        logic take_new;
    } aet_win_ctrl_t;

endpackage

// ===== rtl/aet_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_window
// Sample window held as a circular shift line; one entry leaves at the tail
// per shift, either recirculated to the head or replaced by a new sample.
// ----------------------------------------------------------------------------
module aet_window
    import aet_pkg::*;
#(
    parameter int WINDOW_LEN = AET_WINDOW_LEN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  aet_win_ctrl_t              ctrl,
    input  logic signed [SAMPLE_W-1:0] new_sample,
    output logic signed [SAMPLE_W-1:0] tail
);

    logic signed [SAMPLE_W-1:0] win_reg [WINDOW_LEN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (ctrl.shift) begin
            win_reg[0] <= ctrl.take_new ? new_sample : win_reg[WINDOW_LEN-1];
            for (int i = 1; i < WINDOW_LEN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    assign tail = win_reg[WINDOW_LEN-1];

endmodule

// ===== rtl/aet_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aet_div
// Serial restoring divider by a constant, one quotient bit per cycle,
// signed dividend, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module aet_div
    import aet_pkg::*;
#(
    parameter int DIVIDEND_W = 37,
    parameter int DIVISOR    = AET_WINDOW_LEN
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    output logic                         done,
    output logic signed [SAMPLE_W-1:0]   quotient
);

    localparam int REM_W = $clog2(DIVISOR) + 1;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [REM_W:0]   DIV_C   = (REM_W + 1)'(DIVISOR);
    localparam logic [CNT_W-1:0] STEPS   = CNT_W'(DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [DIVIDEND_W-1:0] mag_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic [REM_W:0]        trial;
    logic                  q_bit;
    logic [SAMPLE_W-1:0]   q_mag;

    assign trial = {rem_reg, mag_reg[DIVIDEND_W-1]};
    assign q_bit = (trial >= DIV_C);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= STEPS;
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - CNT_ONE;
                done_reg <= (cnt_reg == CNT_ONE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DIVIDEND_W-1];
            mag_reg <= dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1)) : dividend;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= q_bit ? REM_W'(trial - DIV_C) : trial[REM_W-1:0];
            mag_reg <= {mag_reg[DIVIDEND_W-2:0], q_bit};
        end
    end

    assign q_mag    = mag_reg[SAMPLE_W-1:0];
    assign quotient = neg_reg ? -q_mag : q_mag;
    assign done     = done_reg;

endmodule

// ===== rtl/adaptive_event_trigger_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_event_trigger_top
// Send-on-delta event trigger with a noise-adaptive threshold.
//
// The s_ channel takes one transaction per tick: sample and reference.
// Each accepted transaction yields exactly one m_ transaction carrying fire,
// cause and elapsed_ticks. The cfg channel writes base_threshold (index 0)
// and error_gain (index 1); it is always ready, other indexes are dropped.
// A base_threshold of zero fires every tick (bypass) and goes from
// acceptance straight to the decision state. Otherwise the window is
// pushed and scanned by recirculating it once for the sum, the mean
// comes from a serial divider, and a second recirculation finds the
// largest deviation. One transaction is processed at a time; s_tready
// is high in idle, even while a result waits in the output register. A
// stalled receiver holds the result; the next result waits until it is
// taken. Reset clears the window, the last event error and sets the tick
// count to one; base_threshold resets to 0 and error_gain to 6554.
// ----------------------------------------------------------------------------
module adaptive_event_trigger_top
    import aet_pkg::*;
#(
    parameter int WINDOW_LEN    = AET_WINDOW_LEN,
    parameter int TIMEOUT_TICKS = AET_TIMEOUT_TICKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample[31:0], reference[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // fire[0], cause[2:1], elapsed_ticks[11:3]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int PROD_W = GAIN_W + SAMPLE_W;
    localparam int TH_W   = SAMPLE_W + 2;

    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [15:0]      TIMEOUT = 16'(TIMEOUT_TICKS);

    localparam logic [7:0] REG_BASE = 8'd0;
    localparam logic [7:0] REG_GAIN = 8'd1;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_BYPASS  = 2'd1;
    localparam logic [1:0] CAUSE_DELTA   = 2'd2;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd3;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUM    = 3'd1;
    localparam logic [2:0] ST_DIVGO  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_MAX    = 3'd4;
    localparam logic [2:0] ST_THR    = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;

    logic [2:0]               state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [BASE_W-1:0]        base_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [TICK_W-1:0]        tick_reg;
    logic [SAMPLE_W-1:0]      last_err_reg;
    logic                     bypass_reg;
    logic [SAMPLE_W-1:0]      err_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [GAIN_W-1:0]        term_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0]      noise_reg;
    logic [TH_W-1:0]          th_reg;
    logic [SAMPLE_W-1:0]      delta_reg;
    logic                     m_tvalid_reg;
    logic [15:0]              m_tdata_reg;

    logic                     in_accept;
    logic                     out_load;
    aet_win_ctrl_t            win_ctrl;
    logic signed [SAMPLE_W-1:0] tail;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [SAMPLE_W-1:0] in_ref;
    logic signed [SAMPLE_W:0] in_diff;
    logic [SAMPLE_W-1:0]      in_err;
    logic signed [SAMPLE_W:0] dev;
    logic [SAMPLE_W-1:0]      dev_abs;
    logic signed [SAMPLE_W:0] err_diff;
    logic [PROD_W-FRAC_W-1:0] prod_shr;
    logic                     div_done;
    logic signed [SAMPLE_W-1:0] div_q;
    logic [TICK_W-1:0]        tick_inc;
    logic                     fire_d;
    logic [1:0]               cause_d;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_DECIDE) && (!m_tvalid_reg || m_tready);

    assign in_sample = s_tdata[31:0];
    assign in_ref    = s_tdata[63:32];
    assign in_diff   = {in_ref[SAMPLE_W-1], in_ref} - {in_sample[SAMPLE_W-1], in_sample};
    assign in_err    = in_diff[SAMPLE_W] ? SAMPLE_W'(-in_diff) : in_diff[SAMPLE_W-1:0];

    assign dev      = {tail[SAMPLE_W-1], tail} - {mean_reg[SAMPLE_W-1], mean_reg};
    assign dev_abs  = dev[SAMPLE_W] ? SAMPLE_W'(-dev) : dev[SAMPLE_W-1:0];
    assign err_diff = $signed({1'b0, err_reg}) - $signed({1'b0, last_err_reg});
    assign prod_shr = prod_reg[PROD_W-1:FRAC_W];

    always_comb begin
        win_ctrl.shift    = (in_accept && (base_reg != '0))
                            || (state_reg == ST_SUM) || (state_reg == ST_MAX);
        win_ctrl.take_new = (state_reg == ST_IDLE);
    end

    aet_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (win_ctrl),
        .new_sample (in_sample),
        .tail       (tail)
    );

    aet_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (WINDOW_LEN)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIVGO),
        .dividend (acc_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        tick_inc = (tick_reg < TICK_MAX) ? tick_reg + TICK_W'(1) : tick_reg;
        fire_d   = 1'b1;
        cause_d  = CAUSE_NONE;
        if (bypass_reg) begin
            cause_d = CAUSE_BYPASS;
        end else if (TH_W'(delta_reg) >= th_reg) begin
            cause_d = CAUSE_DELTA;
        end else if (16'(tick_inc) > TIMEOUT) begin
            cause_d = CAUSE_TIMEOUT;
        end else begin
            fire_d = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            base_reg     <= '0;
            gain_reg     <= GAIN_W'(6554);
            tick_reg     <= TICK_W'(1);
            last_err_reg <= '0;
            bypass_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_BASE: base_reg <= cfg_data[BASE_W-1:0];
                    REG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        bypass_reg <= (base_reg == '0);
                        cnt_reg    <= WIN_CNT;
                        state_reg  <= (base_reg == '0) ? ST_DECIDE : ST_SUM;
                    end
                end
                ST_SUM: begin
                    cnt_reg <= cnt_reg - CNT_ONE;
                    if (cnt_reg == CNT_ONE) begin
                        state_reg <= ST_DIVGO;
                    end
                end
                ST_DIVGO: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        cnt_reg   <= WIN_CNT;
                        state_reg <= ST_MAX;
                    end
                end
                ST_MAX: begin
                    cnt_reg <= cnt_reg - CNT_ONE;
                    if (cnt_reg == CNT_ONE) begin
                        state_reg <= ST_THR;
                    end
                end
                ST_THR: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                        if (fire_d) begin
                            tick_reg <= '0;
                            if (!bypass_reg) begin
                                last_err_reg <= err_reg;
                            end
                        end else begin
                            tick_reg <= tick_inc;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            err_reg <= in_err;
            acc_reg <= '0;
        end
        if (state_reg == ST_SUM) begin
            acc_reg  <= acc_reg + {{(SUM_W - SAMPLE_W){tail[SAMPLE_W-1]}}, tail};
            prod_reg <= PROD_W'(gain_reg) * PROD_W'(err_reg);
        end
        if (state_reg == ST_DIVGO) begin
            term_reg  <= (prod_shr > (PROD_W - FRAC_W)'(gain_reg))
                         ? gain_reg : prod_shr[GAIN_W-1:0];
            noise_reg <= '0;
        end
        if (div_done) begin
            mean_reg <= div_q;
        end
        if (state_reg == ST_MAX) begin
            if (dev_abs > noise_reg) begin
                noise_reg <= dev_abs;
            end
        end
        if (state_reg == ST_THR) begin
            th_reg    <= TH_W'(base_reg) + TH_W'(term_reg) + TH_W'(noise_reg);
            delta_reg <= err_diff[SAMPLE_W] ? SAMPLE_W'(-err_diff) : err_diff[SAMPLE_W-1:0];
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0000, (fire_d ? tick_inc : TICK_W'(0)), cause_d, fire_d};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive event trigger.
//
// A behavioral predictor tracks the sample window, the error at the last
// event, the tick count and both registers. It computes fire, cause and
// elapsed ticks for every accepted input transaction. A checker process
// compares each output transaction with the oldest prediction. The tests
// cover bypass after reset, the delta and timeout causes and their
// priority, field and register extremes, and random traffic. The traffic
// runs with bursty input, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import aet_pkg::*;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_BYPASS  = 2'd1,
        CAUSE_DELTA   = 2'd2,
        CAUSE_TIMEOUT = 2'd3
    } trigger_cause_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic                fire;
        trigger_cause_t      cause;
        logic [TICK_W-1:0]   elapsed;
    } decision_t;

    localparam logic [7:0] REG_BASE_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_ERROR_GAIN     = 8'd1;
    localparam int         STALL_LIMIT        = 4000;
    localparam int         QUIET_BASE         = 'h1000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // sample[31:0], reference[63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // fire[0], cause[2:1], elapsed_ticks[11:3]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic signed [SAMPLE_W-1:0] win [AET_WINDOW_LEN];
    logic [SAMPLE_W-1:0]        last_err;
    logic [TICK_W-1:0]          ticks;
    logic [BASE_W-1:0]          base_th;
    logic [GAIN_W-1:0]          gain;

    decision_t pending_decisions[$];

    int       n_errors;
    int       samples_sent;
    int       reg_writes;
    int       n_bypass;
    int       n_delta;
    int       n_timeout;
    int       n_quiet;
    int       burst_left;
    int       gap_max;
    int       rx_cycle;
    rx_mode_t rx_mode;
    logic     rx_hold_off;
    longint   track_level;

    adaptive_event_trigger_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic decision_t decide_trigger(input logic signed [31:0] smp,
                                                 input logic signed [31:0] setpt);
        longint    err;
        longint    acc;
        longint    avg;
        longint    spread;
        longint    dev;
        longint    term;
        longint    thresh;
        longint    delta;
        decision_t d;
        d.fire    = 1'b0;
        d.cause   = CAUSE_NONE;
        d.elapsed = '0;
        err = longint'(setpt) - longint'(smp);
        if (err < 0) err = -err;
        if (base_th == '0) begin
            if (ticks < TICK_MAX) ticks++;
            d.fire    = 1'b1;
            d.cause   = CAUSE_BYPASS;
            d.elapsed = ticks;
            ticks     = '0;
            return d;
        end
        for (int i = AET_WINDOW_LEN - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = smp;
        acc = 0;
        for (int i = 0; i < AET_WINDOW_LEN; i++) acc += longint'(win[i]);
        avg = acc / AET_WINDOW_LEN;
        spread = 0;
        for (int i = 0; i < AET_WINDOW_LEN; i++) begin
            dev = longint'(win[i]) - avg;
            if (dev < 0) dev = -dev;
            if (dev > spread) spread = dev;
        end
        term = (longint'(gain) * err) >>> FRAC_W;
        if (term > longint'(gain)) term = longint'(gain);
        thresh = longint'(base_th) + term + spread;
        delta  = err - longint'(last_err);
        if (delta < 0) delta = -delta;
        if (ticks < TICK_MAX) ticks++;
        if (delta >= thresh) begin
            d.fire  = 1'b1;
            d.cause = CAUSE_DELTA;
        end else if (ticks > AET_TIMEOUT_TICKS) begin
            d.fire  = 1'b1;
            d.cause = CAUSE_TIMEOUT;
        end
        if (d.fire) begin
            last_err  = err[31:0];
            d.elapsed = ticks;
            ticks     = '0;
        end
        return d;
    endfunction

    task automatic flag_error(input string msg);
        if (n_errors < 50) $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic offer_sample(input logic signed [31:0] smp,
                                input logic signed [31:0] setpt);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0) gap = $urandom_range(0, gap_max);
        end
        burst_left--;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {setpt, smp};
        s_tvalid = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_decisions.push_back(decide_trigger(smp, setpt));
        samples_sent++;
    endtask

    task automatic write_register(input logic [7:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        if (idx == REG_BASE_THRESHOLD) base_th = value[BASE_W-1:0];
        else if (idx == REG_ERROR_GAIN) gain = value[GAIN_W-1:0];
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // error stays within QUIET_BASE of the last event error, so no delta fire
    task automatic send_steady_error();
        longint s;
        longint e;
        longint j;
        logic signed [31:0] smp;
        logic signed [31:0] setpt;
        s = longint'($urandom_range(0, 65535)) - 32768;
        j = longint'($urandom_range(0, QUIET_BASE - 2));
        if ($urandom_range(0, 1) == 1 && longint'(last_err) >= j) e = longint'(last_err) - j;
        else e = longint'(last_err) + j;
        smp   = s[31:0];
        e     = s + e;
        setpt = e[31:0];
        offer_sample(smp, setpt);
    endtask

    task automatic send_random_item();
        logic signed [31:0] smp;
        logic signed [31:0] setpt;
        longint lvl_s;
        longint lvl_r;
        case ($urandom_range(0, 9))
            0, 1: begin
                smp   = $urandom;
                setpt = $urandom;
            end
            8: begin
                smp   = pick_extreme();
                setpt = pick_extreme();
            end
            9: begin
                smp   = $urandom;
                setpt = smp;
            end
            default: begin
                if ($urandom_range(0, 7) == 0)
                    track_level = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
                lvl_s = track_level + longint'($urandom_range(0, 8191)) - 4096;
                lvl_r = track_level + longint'($urandom_range(0, 32767)) - 16384;
                if ($urandom_range(0, 15) == 0) lvl_r += longint'($urandom_range(0, 1 << 22));
                smp   = lvl_s[31:0];
                setpt = lvl_r[31:0];
            end
        endcase
        offer_sample(smp, setpt);
    endtask

    task automatic test_bypass_after_reset();
        gap_max = 3;
        rx_mode = RX_RANDOM;
        offer_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
        offer_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        offer_sample(32'sh0, 32'sh0);
        offer_sample(-32'sd1, 32'sd1);
        offer_sample($urandom, $urandom);
        settle();
    endtask

    task automatic test_delta_versus_timeout();
        longint s;
        longint r;
        s = 0;
        write_register(REG_BASE_THRESHOLD, QUIET_BASE);
        write_register(REG_ERROR_GAIN, 32'h000F_FFFF);
        gap_max = 10;
        rx_mode = RX_PATTERN;
        while (ticks < AET_TIMEOUT_TICKS) send_steady_error();
        // delta and timeout due on the same tick: delta wins
        s = longint'($urandom_range(0, 65535)) - 32768;
        r = s + (1 << 30) + longint'($urandom_range(0, 1 << 20));
        offer_sample(s[31:0], r[31:0]);
        while (ticks < AET_TIMEOUT_TICKS) send_steady_error();
        send_steady_error();
        settle();
    endtask

    task automatic test_field_extremes();
        write_register(REG_BASE_THRESHOLD, 32'hFFFF_FFFF);
        write_register(REG_ERROR_GAIN, 32'hFFFF_FFFF);
        write_register(REG_ERROR_GAIN + 8'd1, $urandom);
        write_register(8'hFF, $urandom);
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        offer_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
        offer_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        offer_sample(32'sh0, 32'sh0);
        offer_sample(-32'sd1, 32'sh0);
        offer_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        offer_sample(32'sh8000_0000, 32'sh8000_0000);
        offer_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
        settle();
    endtask

    task automatic test_min_threshold();
        write_register(REG_BASE_THRESHOLD, 32'd1);
        write_register(REG_ERROR_GAIN, 32'd0);
        gap_max = 5;
        rx_mode = RX_RANDOM;
        offer_sample(32'sh0, 32'sh1);
        offer_sample(32'sh0, 32'sh0);
        offer_sample(32'sh1, 32'sh0);
        offer_sample(32'sh1234_5678, -32'sh1234_5678);
        offer_sample(32'sh0001_0000, 32'sh0001_0000);
        offer_sample(32'sh7FFF_0000, 32'sh8000_FFFF);
        settle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_register(REG_BASE_THRESHOLD, $urandom_range(1, 'hFFFF));
                    write_register(REG_ERROR_GAIN, $urandom);
                    gap_max = 40;
                    rx_mode = RX_RANDOM;
                end
                1: begin
                    write_register(REG_BASE_THRESHOLD, 32'h7FFF_FFFF);
                    write_register(REG_ERROR_GAIN, 32'd0);
                    gap_max = 0;
                    rx_mode = RX_ALWAYS;
                end
                2: begin
                    write_register(REG_BASE_THRESHOLD, $urandom);
                    write_register(REG_ERROR_GAIN, 32'h000F_FFFF);
                    gap_max = 120;
                    rx_mode = RX_PATTERN;
                    fork
                        begin
                            repeat (200) @(posedge aclk);
                            rx_hold_off = 1'b1;
                            repeat (700) @(posedge aclk);
                            rx_hold_off = 1'b0;
                        end
                    join_none
                end
                3: begin
                    write_register(REG_BASE_THRESHOLD, 32'd0);
                    write_register(REG_ERROR_GAIN, $urandom);
                    gap_max = 20;
                    rx_mode = RX_RANDOM;
                end
                default: begin
                    write_register(REG_BASE_THRESHOLD, 32'd1);
                    write_register(REG_ERROR_GAIN, 32'd6554);
                    gap_max = 8;
                    rx_mode = RX_PATTERN;
                end
            endcase
            write_register(8'($urandom_range(2, 255)), $urandom);
            repeat (50) send_random_item();
            settle();
        end
    endtask

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_hold_off) begin
            m_tready = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready = 1'b1;
                RX_RANDOM: m_tready = ($urandom_range(0, 3) != 0);
                default:   m_tready = ((rx_cycle % 13) < 8);
            endcase
        end
    end

    always @(posedge aclk) begin
        decision_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decisions.size() == 0) begin
                flag_error($sformatf("unexpected result transaction %h", m_tdata));
            end else begin
                want = pending_decisions.pop_front();
                if (m_tdata[0] !== want.fire)
                    flag_error($sformatf("fire %b, expected %b", m_tdata[0], want.fire));
                if (m_tdata[2:1] !== want.cause)
                    flag_error($sformatf("cause %0d, expected %0d", m_tdata[2:1], want.cause));
                if (m_tdata[11:3] !== want.elapsed)
                    flag_error($sformatf("elapsed %0d, expected %0d",
                                         m_tdata[11:3], want.elapsed));
                if (m_tdata[15:12] !== 4'b0)
                    flag_error($sformatf("padding bits %b not zero", m_tdata[15:12]));
                case (want.cause)
                    CAUSE_BYPASS:  n_bypass++;
                    CAUSE_DELTA:   n_delta++;
                    CAUSE_TIMEOUT: n_timeout++;
                    default:       n_quiet++;
                endcase
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("adaptive_event_trigger_top verification failed");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rx_hold_off = 1'b0;
        rx_mode     = RX_ALWAYS;
        rx_cycle    = 0;
        gap_max     = 0;
        burst_left  = 0;
        track_level = 0;
        n_errors    = 0;
        samples_sent = 0;
        reg_writes  = 0;
        n_bypass    = 0;
        n_delta     = 0;
        n_timeout   = 0;
        n_quiet     = 0;
        for (int i = 0; i < AET_WINDOW_LEN; i++) win[i] = '0;
        last_err = '0;
        ticks    = 9'd1;
        base_th  = '0;
        gain     = 20'd6554;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_bypass_after_reset();
        test_delta_versus_timeout();
        test_field_extremes();
        test_min_threshold();
        test_random_traffic();

        settle();
        repeat (100) @(posedge aclk);
        $display("covered %0d input transactions and %0d register writes", samples_sent,
                 reg_writes);
        $display("results: %0d bypass, %0d delta, %0d timeout, %0d no fire", n_bypass,
                 n_delta, n_timeout, n_quiet);
        if (n_errors == 0) begin
            $display("adaptive_event_trigger_top verification clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("adaptive_event_trigger_top verification failed");
        end
        $finish;
    end

endmodule
